// File: hdl/htd_pkg.sv
// htd_pkg: shared widths, datapath operation codes and the controller/datapath
// command and status structs of the huffman tree decoder
// no dependencies
package htd_pkg;

    localparam int SYM_W         = 21;
    localparam int CODE_W        = 32;
    localparam int LEN_W         = 6;
    localparam int BYTE_W        = 8;
    localparam int BITS_PER_BYTE = 8;

    typedef logic [3:0] op_t;

    localparam op_t OP_NONE      = 4'd0;
    localparam op_t OP_ACCEPT    = 4'd1;
    localparam op_t OP_FETCH     = 4'd2;
    localparam op_t OP_D_LOADCUR = 4'd3;
    localparam op_t OP_D_STEP    = 4'd4;
    localparam op_t OP_D_LAND    = 4'd5;
    localparam op_t OP_L_STEP    = 4'd6;
    localparam op_t OP_L_LINK    = 4'd7;
    localparam op_t OP_L_NEW     = 4'd8;
    localparam op_t OP_L_SYM     = 4'd9;
    localparam op_t OP_L_ERR     = 4'd10;
    localparam op_t OP_FLUSH     = 4'd11;

    typedef struct packed {
        op_t op;
    } cmd_t;

    typedef struct packed {
        logic mode;
        logic cnt_zero;
        logic cnt_last;
        logic dec_miss;
        logic load_miss;
        logic rd_leaf;
        logic full;
        logic emit_ok;
        logic flush_ok;
        logic pend_valid;
    } sts_t;

endpackage

// File: hdl/htd_in_if.sv
// htd_in_if: input item channel of the huffman tree decoder
// depends on htd_pkg for field widths
interface htd_in_if;
    logic                          valid;
    logic                          ready;
    logic                          mode;
    logic [htd_pkg::SYM_W-1:0]     symbol_in;
    logic [htd_pkg::CODE_W-1:0]    code_bits;
    logic [htd_pkg::LEN_W-1:0]     code_length;
    logic [htd_pkg::BYTE_W-1:0]    data_byte;
    logic                          file_start;

    modport source (
        output valid, mode, symbol_in, code_bits, code_length, data_byte, file_start,
        input  ready
    );

    modport sink (
        input  valid, mode, symbol_in, code_bits, code_length, data_byte, file_start,
        output ready
    );
endinterface

// File: hdl/htd_out_if.sv
// htd_out_if: result item channel of the huffman tree decoder
// depends on htd_pkg for field widths
interface htd_out_if;
    logic                          valid;
    logic                          ready;
    logic [htd_pkg::SYM_W-1:0]     symbol_out;
    logic                          error;
    logic                          last_of_run;

    modport source (
        output valid, symbol_out, error, last_of_run,
        input  ready
    );

    modport sink (
        input  valid, symbol_out, error, last_of_run,
        output ready
    );
endinterface

// File: hdl/huffman_tree_decoder.sv
// huffman_tree_decoder: top level, joins the sequencer and the datapath
// depends on htd_pkg, htd_in_if, htd_out_if, htd_ctrl, htd_dpath
//
// usage
// - items carries one item per valid/ready handshake: mode 0 loads one code
//   entry (symbol_in, code_bits, code_length), mode 1 decodes data_byte
//   msb first; a decode item with file_start starts at the root
// - results carries the decoded symbols; error marks a missing branch or a
//   full node table, last_of_run marks the final result of one item
// - items are taken one at a time; items.ready is high only while idle
// - decode: fetch the walk node, then for each bit either a missing
//   branch (an error result, back to the root) or a taken branch (one
//   node table read before each leaf test), then release the last result
// - load: follow the existing prefix of the code, create one node per
//   missing bit and write the symbol; when the table is full, send an
//   error result instead and write nothing
// - results leave from an output register behind a one-result staging
//   register; a stalled receiver holds the result there and the block
//   waits only when both hold a result and another one is due
// - reset leaves the tree with the root alone and the walk at the root;
//   the root links are flip-flops, so no clearing pass runs and items are
//   taken as soon as reset is released
module huffman_tree_decoder #(
    parameter int NODE_SLOTS   = 512,
    parameter int MAX_CODE_LEN = 32
) (
    input  logic       clk,
    input  logic       rst_n,
    htd_in_if.sink     items,
    htd_out_if.source  results
);

    htd_pkg::cmd_t cmd;
    htd_pkg::sts_t sts;

    // sequencer: picks one datapath operation per cycle
    htd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (items.valid),
        .in_ready (items.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // datapath: node table, walk position, node count and result staging
    htd_dpath #(
        .NODE_SLOTS   (NODE_SLOTS),
        .MAX_CODE_LEN (MAX_CODE_LEN)
    ) u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .mode        (items.mode),
        .symbol_in   (items.symbol_in),
        .code_bits   (items.code_bits),
        .code_length (items.code_length),
        .data_byte   (items.data_byte),
        .file_start  (items.file_start),
        .out_ready   (results.ready),
        .out_valid   (results.valid),
        .symbol_out  (results.symbol_out),
        .error       (results.error),
        .last_of_run (results.last_of_run)
    );

endmodule

// File: hdl/htd_ram.sv
// htd_ram: generic single write port, single read port ram with registered read
// no dependencies
module htd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: hdl/htd_ctrl.sv
// htd_ctrl: sequencer of the huffman tree decoder, one datapath operation per cycle
// depends on htd_pkg for the command and status structs
module htd_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  htd_pkg::sts_t sts,
    output htd_pkg::cmd_t cmd
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_FETCH = 4'd1;
    localparam logic [3:0] S_DCUR  = 4'd2;
    localparam logic [3:0] S_DSTEP = 4'd3;
    localparam logic [3:0] S_DWAIT = 4'd4;
    localparam logic [3:0] S_LSTEP = 4'd5;
    localparam logic [3:0] S_LCHK  = 4'd6;
    localparam logic [3:0] S_LLINK = 4'd7;
    localparam logic [3:0] S_LNEW  = 4'd8;
    localparam logic [3:0] S_LSYM  = 4'd9;
    localparam logic [3:0] S_LERR  = 4'd10;
    localparam logic [3:0] S_FLUSH = 4'd11;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd.op     = htd_pkg::OP_NONE;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.op     = htd_pkg::OP_ACCEPT;
                    state_next = S_FETCH;
                end
            end
            S_FETCH:
            begin
                cmd.op     = htd_pkg::OP_FETCH;
                state_next = sts.mode ? S_DCUR : S_LSTEP;
            end
            S_DCUR:
            begin
                cmd.op     = htd_pkg::OP_D_LOADCUR;
                state_next = S_DSTEP;
            end
            S_DSTEP:
            begin
                if (!sts.dec_miss)
                begin
                    cmd.op     = htd_pkg::OP_D_STEP;
                    state_next = S_DWAIT;
                end
                else if (sts.emit_ok)
                begin
                    cmd.op     = htd_pkg::OP_D_STEP;
                    state_next = sts.cnt_last ? S_FLUSH : S_DSTEP;
                end
            end
            S_DWAIT:
            begin
                // a leaf needs room in the result staging, an inner node does not
                if (!sts.rd_leaf || sts.emit_ok)
                begin
                    cmd.op     = htd_pkg::OP_D_LAND;
                    state_next = sts.cnt_last ? S_FLUSH : S_DSTEP;
                end
            end
            S_LSTEP:
            begin
                if (sts.cnt_zero)
                begin
                    state_next = S_LSYM;
                end
                else
                begin
                    cmd.op = htd_pkg::OP_L_STEP;
                    if (sts.load_miss)
                    begin
                        state_next = S_LCHK;
                    end
                end
            end
            S_LCHK:
            begin
                state_next = sts.full ? S_LERR : S_LLINK;
            end
            S_LLINK:
            begin
                cmd.op     = htd_pkg::OP_L_LINK;
                state_next = S_LNEW;
            end
            S_LNEW:
            begin
                cmd.op = htd_pkg::OP_L_NEW;
                if (sts.cnt_zero)
                begin
                    state_next = S_LSYM;
                end
            end
            S_LSYM:
            begin
                cmd.op     = htd_pkg::OP_L_SYM;
                state_next = S_IDLE;
            end
            S_LERR:
            begin
                if (sts.emit_ok)
                begin
                    cmd.op     = htd_pkg::OP_L_ERR;
                    state_next = S_FLUSH;
                end
            end
            S_FLUSH:
            begin
                if (!sts.pend_valid)
                begin
                    state_next = S_IDLE;
                end
                else if (sts.flush_ok)
                begin
                    cmd.op     = htd_pkg::OP_FLUSH;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// File: hdl/htd_dpath.sv
// htd_dpath: node table, walk registers and result staging of the huffman tree decoder
// depends on htd_pkg and htd_ram
module htd_dpath #(
    parameter int NODE_SLOTS   = 512,
    parameter int MAX_CODE_LEN = 32
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  htd_pkg::cmd_t               cmd,
    output htd_pkg::sts_t               sts,
    input  logic                        mode,
    input  logic [htd_pkg::SYM_W-1:0]   symbol_in,
    input  logic [htd_pkg::CODE_W-1:0]  code_bits,
    input  logic [htd_pkg::LEN_W-1:0]   code_length,
    input  logic [htd_pkg::BYTE_W-1:0]  data_byte,
    input  logic                        file_start,
    input  logic                        out_ready,
    output logic                        out_valid,
    output logic [htd_pkg::SYM_W-1:0]   symbol_out,
    output logic                        error,
    output logic                        last_of_run
);

    localparam int W  = $clog2(NODE_SLOTS);
    localparam int NW = $clog2(NODE_SLOTS + 1);
    localparam int LW = $clog2(MAX_CODE_LEN + 1);
    localparam int CW = (LW > 4) ? LW : 4;
    localparam int XW = NW + 8;
    localparam int SW = htd_pkg::SYM_W;

    // item fields
    logic                        mode_reg, mode_next;
    logic [SW-1:0]               sym_reg, sym_next;
    logic [htd_pkg::CODE_W-1:0]  code_reg, code_next;
    logic [htd_pkg::BYTE_W-1:0]  byte_reg, byte_next;
    logic [CW-1:0]               cnt_reg, cnt_next;

    // walk state
    logic [W-1:0]                node_reg, node_next;
    logic [W-1:0]                walk_reg, walk_next;
    logic [W-1:0]                nxt_reg, nxt_next;
    logic [2*W-1:0]              cur_reg, cur_next;
    logic [2*W-1:0]              root_reg, root_next;
    logic                        rd_zero_reg, rd_zero_next;
    logic [NW-1:0]               used_reg, used_next;

    // result staging: pending result waits until its last flag is known
    logic                        pend_valid_reg, pend_valid_next;
    logic [SW-1:0]               pend_sym_reg, pend_sym_next;
    logic                        pend_err_reg, pend_err_next;
    logic                        out_valid_reg, out_valid_next;
    logic [SW-1:0]               out_sym_reg, out_sym_next;
    logic                        out_err_reg, out_err_next;
    logic                        out_last_reg, out_last_next;

    // node table ports
    logic                        link_we;
    logic [W-1:0]                link_waddr;
    logic [2*W-1:0]              link_wdata;
    logic [2*W-1:0]              link_q;
    logic                        sym_we;
    logic [SW-1:0]               sym_q;
    logic                        rd_en;
    logic [W-1:0]                rd_addr;

    logic [2*W-1:0]              links_q;
    logic [6:0]                  pos7;
    logic                        code_bit;
    logic [W-1:0]                dec_nxt;
    logic [W-1:0]                load_nxt;
    logic [W-1:0]                new_idx;
    logic [NW-1:0]               free_slots;
    logic [6:0]                  len7;
    logic [6:0]                  len_sat;
    logic                        out_free;
    logic                        emit;
    logic [SW-1:0]               emit_sym;
    logic                        emit_err;
    logic                        flush;

    htd_ram #(
        .WIDTH (2 * W),
        .DEPTH (NODE_SLOTS)
    ) u_link_ram (
        .clk   (clk),
        .we    (link_we),
        .waddr (link_waddr),
        .wdata (link_wdata),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (link_q)
    );

    htd_ram #(
        .WIDTH (SW),
        .DEPTH (NODE_SLOTS)
    ) u_sym_ram (
        .clk   (clk),
        .we    (sym_we),
        .waddr (node_reg),
        .wdata (sym_reg),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (sym_q)
    );

    // root links live in flip-flops, so the table needs no clearing after reset
    assign links_q    = rd_zero_reg ? root_reg : link_q;
    assign pos7       = 7'(cnt_reg) - 7'd1;
    assign code_bit   = (pos7 < 7'd32) ? code_reg[pos7[4:0]] : 1'b0;
    assign dec_nxt    = byte_reg[htd_pkg::BYTE_W-1] ? cur_reg[2*W-1:W] : cur_reg[W-1:0];
    assign load_nxt   = code_bit ? links_q[2*W-1:W] : links_q[W-1:0];
    assign new_idx    = used_reg[W-1:0];
    assign free_slots = NW'(NODE_SLOTS) - used_reg;
    assign len7       = {1'b0, code_length};
    assign len_sat    = (len7 > 7'(MAX_CODE_LEN)) ? 7'(MAX_CODE_LEN) : len7;
    assign out_free   = !out_valid_reg || out_ready;

    always_comb
    begin
        sts.mode       = mode_reg;
        sts.cnt_zero   = (cnt_reg == '0);
        sts.cnt_last   = (cnt_reg == CW'(1));
        sts.dec_miss   = (dec_nxt == '0);
        sts.load_miss  = (load_nxt == '0);
        sts.rd_leaf    = (links_q == '0);
        sts.full       = (XW'(cnt_reg) > XW'(free_slots));
        sts.emit_ok    = !pend_valid_reg || out_free;
        sts.flush_ok   = out_free;
        sts.pend_valid = pend_valid_reg;
    end

    always_comb
    begin
        mode_next       = mode_reg;
        sym_next        = sym_reg;
        code_next       = code_reg;
        byte_next       = byte_reg;
        cnt_next        = cnt_reg;
        node_next       = node_reg;
        walk_next       = walk_reg;
        nxt_next        = nxt_reg;
        cur_next        = cur_reg;
        root_next       = root_reg;
        rd_zero_next    = rd_zero_reg;
        used_next       = used_reg;
        pend_valid_next = pend_valid_reg;
        pend_sym_next   = pend_sym_reg;
        pend_err_next   = pend_err_reg;
        out_valid_next  = out_valid_reg;
        out_sym_next    = out_sym_reg;
        out_err_next    = out_err_reg;
        out_last_next   = out_last_reg;
        link_we         = 1'b0;
        link_waddr      = node_reg;
        link_wdata      = '0;
        sym_we          = 1'b0;
        rd_en           = 1'b0;
        rd_addr         = node_reg;
        emit            = 1'b0;
        emit_sym        = '0;
        emit_err        = 1'b0;
        flush           = 1'b0;

        case (cmd.op)
            htd_pkg::OP_ACCEPT:
            begin
                mode_next = mode;
                sym_next  = symbol_in;
                code_next = code_bits;
                byte_next = data_byte;
                node_next = '0;
                if (mode)
                begin
                    cnt_next = CW'(htd_pkg::BITS_PER_BYTE);
                    if (file_start)
                    begin
                        walk_next = '0;
                    end
                end
                else
                begin
                    cnt_next = CW'(len_sat);
                end
            end
            htd_pkg::OP_FETCH:
            begin
                rd_en   = 1'b1;
                rd_addr = mode_reg ? walk_reg : node_reg;
            end
            htd_pkg::OP_D_LOADCUR:
            begin
                cur_next = links_q;
            end
            htd_pkg::OP_D_STEP:
            begin
                if (dec_nxt == '0)
                begin
                    // missing branch: error item and back to the root
                    emit      = 1'b1;
                    emit_err  = 1'b1;
                    walk_next = '0;
                    cur_next  = root_reg;
                    byte_next = {byte_reg[htd_pkg::BYTE_W-2:0], 1'b0};
                    cnt_next  = cnt_reg - CW'(1);
                end
                else
                begin
                    rd_en    = 1'b1;
                    rd_addr  = dec_nxt;
                    nxt_next = dec_nxt;
                end
            end
            htd_pkg::OP_D_LAND:
            begin
                if (links_q == '0)
                begin
                    emit      = 1'b1;
                    emit_sym  = sym_q;
                    walk_next = '0;
                    cur_next  = root_reg;
                end
                else
                begin
                    walk_next = nxt_reg;
                    cur_next  = links_q;
                end
                byte_next = {byte_reg[htd_pkg::BYTE_W-2:0], 1'b0};
                cnt_next  = cnt_reg - CW'(1);
            end
            htd_pkg::OP_L_STEP:
            begin
                if (load_nxt == '0)
                begin
                    cur_next = links_q;
                end
                else
                begin
                    node_next = load_nxt;
                    cnt_next  = cnt_reg - CW'(1);
                    rd_en     = 1'b1;
                    rd_addr   = load_nxt;
                end
            end
            htd_pkg::OP_L_LINK:
            begin
                // hang the first new node under the existing parent
                link_we    = 1'b1;
                link_wdata = code_bit ? {new_idx, cur_reg[W-1:0]}
                                      : {cur_reg[2*W-1:W], new_idx};
                node_next  = new_idx;
                used_next  = used_reg + NW'(1);
                cnt_next   = cnt_reg - CW'(1);
            end
            htd_pkg::OP_L_NEW:
            begin
                link_we = 1'b1;
                if (cnt_reg != '0)
                begin
                    link_wdata = code_bit ? {new_idx, {W{1'b0}}} : {{W{1'b0}}, new_idx};
                    node_next  = new_idx;
                    used_next  = used_reg + NW'(1);
                    cnt_next   = cnt_reg - CW'(1);
                end
            end
            htd_pkg::OP_L_SYM:
            begin
                sym_we = 1'b1;
            end
            htd_pkg::OP_L_ERR:
            begin
                emit      = 1'b1;
                emit_err  = 1'b1;
                walk_next = '0;
            end
            htd_pkg::OP_FLUSH:
            begin
                flush = 1'b1;
            end
            default:
            begin
            end
        endcase

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (emit)
        begin
            if (pend_valid_reg)
            begin
                out_valid_next = 1'b1;
                out_sym_next   = pend_sym_reg;
                out_err_next   = pend_err_reg;
                out_last_next  = 1'b0;
            end
            pend_valid_next = 1'b1;
            pend_sym_next   = emit_sym;
            pend_err_next   = emit_err;
        end
        if (flush)
        begin
            out_valid_next  = 1'b1;
            out_sym_next    = pend_sym_reg;
            out_err_next    = pend_err_reg;
            out_last_next   = 1'b1;
            pend_valid_next = 1'b0;
        end

        if (link_we && (link_waddr == '0))
        begin
            root_next = link_wdata;
        end
        if (rd_en)
        begin
            rd_zero_next = (rd_addr == '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            walk_reg       <= '0;
            root_reg       <= '0;
            rd_zero_reg    <= 1'b0;
            used_reg       <= NW'(1);
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            walk_reg       <= walk_next;
            root_reg       <= root_next;
            rd_zero_reg    <= rd_zero_next;
            used_reg       <= used_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg     <= mode_next;
        sym_reg      <= sym_next;
        code_reg     <= code_next;
        byte_reg     <= byte_next;
        cnt_reg      <= cnt_next;
        node_reg     <= node_next;
        nxt_reg      <= nxt_next;
        cur_reg      <= cur_next;
        pend_sym_reg <= pend_sym_next;
        pend_err_reg <= pend_err_next;
        out_sym_reg  <= out_sym_next;
        out_err_reg  <= out_err_next;
        out_last_reg <= out_last_next;
    end

    assign out_valid   = out_valid_reg;
    assign symbol_out  = out_sym_reg;
    assign error       = out_err_reg;
    assign last_of_run = out_last_reg;

endmodule

// File: hdl/htd_checker.sv
// htd_checker: port level checks of the huffman tree decoder, bound to the top level
// depends on htd_pkg for field widths
module htd_checker (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      in_valid,
    input logic                      in_ready,
    input logic                      out_valid,
    input logic                      out_ready,
    input logic [htd_pkg::SYM_W-1:0] symbol_out,
    input logic                      error,
    input logic                      last_of_run
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable({symbol_out, error, last_of_run}))
        else $error("result changed while stalled");

    // one item at a time: busy right after an accept
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("item accepted while busy");

    // error results carry symbol zero
    a_err_symbol: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && error |-> symbol_out == '0)
        else $error("error result with nonzero symbol");

endmodule

bind huffman_tree_decoder htd_checker u_htd_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (items.valid),
    .in_ready    (items.ready),
    .out_valid   (results.valid),
    .out_ready   (results.ready),
    .symbol_out  (results.symbol_out),
    .error       (results.error),
    .last_of_run (results.last_of_run)
);

// File: dv/tb.sv
`timescale 1ns / 100ps
// tb: self-checking testbench of huffman_tree_decoder, with a scoreboard class that
// predicts the code tree, its load and decode walks, and checks every result item
// depends on htd_pkg, htd_in_if, htd_out_if and the huffman_tree_decoder rtl
module tb;
    localparam int SYM_W         = htd_pkg::SYM_W;
    localparam int CODE_W        = htd_pkg::CODE_W;
    localparam int LEN_W         = htd_pkg::LEN_W;
    localparam int BYTE_W        = htd_pkg::BYTE_W;
    localparam int BITS_PER_BYTE = htd_pkg::BITS_PER_BYTE;

    localparam int NODE_SLOTS   = 512;
    localparam int MAX_CODE_LEN = 32;

    // item modes
    localparam logic MODE_LOAD   = 1'b0;
    localparam logic MODE_DECODE = 1'b1;

    // sizes of the run
    localparam int RANDOM_ITEMS = 220;
    localparam int TAIL_ITEMS   = 40;
    localparam int FULL_TARGET  = 4;
    localparam int HOLD_CYCLES  = 400;

    typedef struct packed {
        logic              mode;
        logic [SYM_W-1:0]  symbol_in;
        logic [CODE_W-1:0] code_bits;
        logic [LEN_W-1:0]  code_length;
        logic [BYTE_W-1:0] data_byte;
        logic              file_start;
    } in_item_t;

    typedef struct packed {
        logic [SYM_W-1:0] symbol;
        logic             error;
        logic             last_of_run;
    } result_t;

    // code tree predictor plus the store of decoded symbols still due
    class tree_scoreboard;
        logic [8:0]       left_child [NODE_SLOTS];
        logic [8:0]       right_child[NODE_SLOTS];
        logic [SYM_W-1:0] leaf_code_point[NODE_SLOTS];
        int               node_count;
        logic [8:0]       walk_node;
        result_t          symbols_due[$];
        int               failures;
        int               results_checked;
        int               error_results;
        int               full_events;

        function new();
            for (int i = 0; i < NODE_SLOTS; i++)
            begin
                left_child[i]      = '0;
                right_child[i]     = '0;
                leaf_code_point[i] = '0;
            end
            node_count      = 1;
            walk_node       = '0;
            failures        = 0;
            results_checked = 0;
            error_results   = 0;
            full_events     = 0;
        endfunction

        // accepted input item: update the tree or walk it, queue the results
        function void note_item(in_item_t it);
            int         len;
            int         needed;
            int         pos;
            logic [8:0] node;
            logic [8:0] next;
            logic       dir;
            result_t    run[$];
            result_t    r;
            if (it.mode == MODE_DECODE)
            begin
                // file start puts the walk back at the root
                if (it.file_start)
                    walk_node = '0;
                for (int b = BITS_PER_BYTE - 1; b >= 0; b--)
                begin
                    dir  = it.data_byte[b];
                    next = dir ? right_child[walk_node] : left_child[walk_node];
                    if (next == '0)
                    begin
                        // missing branch
                        r.symbol      = '0;
                        r.error       = 1'b1;
                        r.last_of_run = 1'b0;
                        run.push_back(r);
                        walk_node = '0;
                    end
                    else if (left_child[next] == '0 && right_child[next] == '0)
                    begin
                        r.symbol      = leaf_code_point[next];
                        r.error       = 1'b0;
                        r.last_of_run = 1'b0;
                        run.push_back(r);
                        walk_node = '0;
                    end
                    else
                        walk_node = next;
                end
                if (run.size() > 0)
                    run[run.size() - 1].last_of_run = 1'b1;
                foreach (run[k])
                    symbols_due.push_back(run[k]);
            end
            else
            begin
                len = int'(it.code_length);
                if (len > MAX_CODE_LEN)
                    len = MAX_CODE_LEN;
                // count missing nodes before touching the table
                needed = 0;
                node   = '0;
                for (int i = 0; i < len; i++)
                begin
                    pos  = len - 1 - i;
                    dir  = (pos < CODE_W) ? it.code_bits[pos] : 1'b0;
                    next = dir ? right_child[node] : left_child[node];
                    if (next == '0)
                    begin
                        needed = len - i;
                        break;
                    end
                    node = next;
                end
                if (needed > NODE_SLOTS - node_count)
                begin
                    // table full: nothing written, one error result
                    walk_node     = '0;
                    r.symbol      = '0;
                    r.error       = 1'b1;
                    r.last_of_run = 1'b1;
                    symbols_due.push_back(r);
                    full_events++;
                    return;
                end
                node = '0;
                for (int i = 0; i < len; i++)
                begin
                    pos  = len - 1 - i;
                    dir  = (pos < CODE_W) ? it.code_bits[pos] : 1'b0;
                    next = dir ? right_child[node] : left_child[node];
                    if (next == '0)
                    begin
                        next = node_count[8:0];
                        node_count++;
                        left_child[next]  = '0;
                        right_child[next] = '0;
                        if (dir)
                            right_child[node] = next;
                        else
                            left_child[node] = next;
                    end
                    node = next;
                end
                leaf_code_point[node] = it.symbol_in;
            end
        endfunction

        // accepted result item against the oldest one due
        function void check_result(logic [SYM_W-1:0] symbol, logic error, logic last_of_run);
            result_t want;
            if (symbols_due.size() == 0)
            begin
                $error("unexpected result: symbol_out %h error %b last_of_run %b",
                       symbol, error, last_of_run);
                failures++;
                return;
            end
            want = symbols_due.pop_front();
            results_checked++;
            if (want.error)
                error_results++;
            if (symbol !== want.symbol)
            begin
                $error("symbol_out: expected %h, actual %h", want.symbol, symbol);
                failures++;
            end
            if (error !== want.error)
            begin
                $error("error: expected %b, actual %b", want.error, error);
                failures++;
            end
            if (last_of_run !== want.last_of_run)
            begin
                $error("last_of_run: expected %b, actual %b", want.last_of_run, last_of_run);
                failures++;
            end
        endfunction

        function int pending();
            return symbols_due.size();
        endfunction

        function void report_leftover();
            if (symbols_due.size() != 0)
            begin
                $error("%0d expected results never arrived", symbols_due.size());
                failures++;
            end
        endfunction
    endclass

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    htd_in_if  items_if ();
    htd_out_if results_if ();

    huffman_tree_decoder #(
        .NODE_SLOTS   (NODE_SLOTS),
        .MAX_CODE_LEN (MAX_CODE_LEN)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .items   (items_if),
        .results (results_if)
    );

    tree_scoreboard sb = new();

    int burst_left   = 1;
    int loads_sent   = 0;
    int bytes_sent   = 0;
    bit hold_off_req = 1'b0;

    // 8 ns clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // load item; the decode byte is a don't care here
    function automatic in_item_t make_load(input logic [SYM_W-1:0] sym,
                                           input logic [CODE_W-1:0] bits,
                                           input logic [LEN_W-1:0] len,
                                           input logic fs);
        in_item_t it;
        it.mode        = MODE_LOAD;
        it.symbol_in   = sym;
        it.code_bits   = bits;
        it.code_length = len;
        it.data_byte   = BYTE_W'($urandom_range(0, 255));
        it.file_start  = fs;
        return it;
    endfunction

    // decode item; load fields carry random junk
    function automatic in_item_t make_byte(input logic [BYTE_W-1:0] data, input logic fs);
        in_item_t it;
        it.mode        = MODE_DECODE;
        it.symbol_in   = SYM_W'($urandom_range(0, 1114111));
        it.code_bits   = $urandom;
        it.code_length = LEN_W'($urandom_range(0, 63));
        it.data_byte   = data;
        it.file_start  = fs;
        return it;
    endfunction

    // offer one item until accepted, then note it and pace the sender
    task automatic send_item(input in_item_t it);
        int gap;
        items_if.valid       <= 1'b1;
        items_if.mode        <= it.mode;
        items_if.symbol_in   <= it.symbol_in;
        items_if.code_bits   <= it.code_bits;
        items_if.code_length <= it.code_length;
        items_if.data_byte   <= it.data_byte;
        items_if.file_start  <= it.file_start;
        @(posedge clk);
        while (!items_if.ready)
            @(posedge clk);
        sb.note_item(it);
        if (it.mode == MODE_DECODE)
            bytes_sent++;
        else
            loads_sent++;
        // bursts of back-to-back items, random gaps between them
        burst_left--;
        if (burst_left <= 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
            if (gap > 0)
            begin
                items_if.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40)
                                                      : $urandom_range(1, 10);
        end
    endtask

    // mostly bytes over the loaded tree, some short loads, a few odd lengths
    task automatic send_random_item();
        int pick;
        int len;
        pick = $urandom_range(0, 99);
        if (pick < 78)
            send_item(make_byte(BYTE_W'($urandom_range(0, 255)), $urandom_range(0, 7) == 0));
        else if (pick < 96)
            send_item(make_load(SYM_W'($urandom_range(0, 1114111)), $urandom,
                                LEN_W'($urandom_range(1, 6)), 1'($urandom_range(0, 1))));
        else
        begin
            // zero length, or above the maximum so it saturates
            len = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(MAX_CODE_LEN + 1, 63);
            send_item(make_load(SYM_W'($urandom_range(0, 1114111)), $urandom, LEN_W'(len),
                                1'($urandom_range(0, 1))));
        end
    endtask

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n && results_if.valid && results_if.ready)
            sb.check_result(results_if.symbol_out, results_if.error, results_if.last_of_run);
    end

    // receiver: segments of different stall styles, plus one long hold-off on request
    initial
    begin
        int style;
        int span;
        results_if.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_off_req)
            begin
                // long hold-off so the output register fills and items back up
                hold_off_req = 1'b0;
                results_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                style = $urandom_range(0, 3);
                span  = $urandom_range(1, 40);
                repeat (span)
                begin
                    case (style)
                        0:       results_if.ready <= 1'b1;
                        1:       results_if.ready <= 1'($urandom_range(0, 1));
                        2:       results_if.ready <= ($urandom_range(0, 3) == 0);
                        default: results_if.ready <= 1'b0;
                    endcase
                    @(posedge clk);
                end
            end
        end
    end

    // stimulus and end of test
    initial
    begin
        int waited;
        int tries;
        items_if.valid       <= 1'b0;
        items_if.mode        <= MODE_LOAD;
        items_if.symbol_in   <= '0;
        items_if.code_bits   <= '0;
        items_if.code_length <= '0;
        items_if.data_byte   <= '0;
        items_if.file_start  <= 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // directed: a small prefix code with the branch 1111 left open
        // upper code bits above the length are junk and must be ignored
        send_item(make_load(21'h000041, 32'hFFFF_FFFC, 6'd2, 1'b1));
        send_item(make_load(21'h10FFFF, 32'h0000_0001, 6'd2, 1'b0));
        send_item(make_load(21'h000000, 32'h0000_0002, 6'd2, 1'b0));
        send_item(make_load(21'h0000E9, 32'h0000_0006, 6'd3, 1'b0));
        send_item(make_load(21'h01F600, 32'hAAAA_AAAE, 6'd4, 1'b1));
        send_item(make_byte(8'h00, 1'b1));
        // all ones runs into the missing branch twice
        send_item(make_byte(8'hFF, 1'b0));
        // ends with the walk parked at an inner node
        send_item(make_byte(8'h1B, 1'b0));
        // load while the walk is parked, then carry on from the same node
        send_item(make_load(21'h000777, 32'h0000_000F, 6'd4, 1'b0));
        send_item(make_byte(8'hF0, 1'b0));
        send_item(make_byte(8'h80, 1'b1));
        // symbol on a node that has children: stays an inner node
        send_item(make_load(21'h000055, 32'h0000_0001, 6'd1, 1'b0));
        send_item(make_byte(8'hC0, 1'b1));
        // zero length writes the root only
        send_item(make_load(21'h001234, 32'h5A5A_5A5A, 6'd0, 1'b0));
        send_item(make_byte(8'h40, 1'b1));
        // length 63 saturates to the maximum, a deep all-ones chain
        send_item(make_load(21'h10FFFF, 32'hFFFF_FFFF, 6'd63, 1'b0));
        send_item(make_byte(8'hFF, 1'b1));
        send_item(make_byte(8'hFF, 1'b0));
        send_item(make_byte(8'hFF, 1'b0));
        send_item(make_byte(8'hFF, 1'b0));
        send_item(make_byte(8'hFE, 1'b1));
        send_item(make_byte(8'h7F, 1'b0));
        send_item(make_byte(8'h55, 1'b0));
        send_item(make_byte(8'hAA, 1'b0));

        // random traffic, with the long receiver hold-off near its start
        hold_off_req = 1'b1;
        repeat (RANDOM_ITEMS) send_random_item();

        // fill the node table with long codes until loads start to fail
        tries = 0;
        while (sb.full_events < FULL_TARGET && tries < 60)
        begin
            send_item(make_load(SYM_W'($urandom_range(0, 1114111)), $urandom,
                                LEN_W'($urandom_range(24, MAX_CODE_LEN)),
                                1'($urandom_range(0, 1))));
            send_item(make_byte(BYTE_W'($urandom_range(0, 255)), 1'b0));
            send_item(make_byte(BYTE_W'($urandom_range(0, 255)),
                                $urandom_range(0, 3) == 0));
            tries++;
        end

        // more traffic on the full table
        repeat (TAIL_ITEMS) send_random_item();

        // sender goes quiet
        items_if.valid <= 1'b0;

        // drain, then let a few byte times pass for anything extra
        waited = 0;
        while (sb.pending() != 0 && waited < 40000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (64) @(posedge clk);
        sb.report_leftover();

        $display("covered %0d loads and %0d decode bytes, %0d results checked",
                 loads_sent, bytes_sent, sb.results_checked);
        $display("of those %0d were error results, %0d from a full node table",
                 sb.error_results, sb.full_events);
        if (sb.failures == 0)
            $display("huffman_tree_decoder test passed");
        else
            $display("huffman_tree_decoder test failed");
        $finish;
    end

    // watchdog, far beyond the slowest correct run
    initial
    begin
        #8_000_000;
        $display("huffman_tree_decoder test failed");
        $finish;
    end
endmodule

// File: huffman_tree_decoder.f
hdl/htd_pkg.sv
hdl/htd_in_if.sv
hdl/htd_out_if.sv
hdl/htd_ram.sv
hdl/htd_ctrl.sv
hdl/htd_dpath.sv
hdl/huffman_tree_decoder.sv
hdl/htd_checker.sv
dv/tb.sv
